FILE: src/brb_pkg.sv
// shared types and constants for the byte ring buffer with burst requests
`default_nettype none

package brb_pkg;

	localparam int unsigned DEPTH_DEF     = 1024;
	localparam int unsigned MAX_BURST_DEF = 64;

	localparam int unsigned CMD_W     = 2;
	localparam int unsigned LEN_W     = 7;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned FILL_W    = 11;
	localparam int unsigned S_TDATA_W = 16;
	localparam int unsigned M_TDATA_W = 24;
	localparam int unsigned S_PAD_W   = S_TDATA_W - LEN_W - BYTE_W;
	localparam int unsigned M_PAD_W   = M_TDATA_W - 1 - BYTE_W - FILL_W - 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUT   = 2'd0,
		CMD_GET   = 2'd1,
		CMD_PEEK  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE   = 1'b0,
		ST_STREAM = 1'b1
	} state_t;

endpackage

`default_nettype wire

FILE: src/brb_ram.sv
// generic simple dual-port ram, one write port, one registered read port
`default_nettype none

module brb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: src/byte_ring_buffer_burst.sv
// top level of the byte ring buffer with all-or-nothing burst requests
//
// usage
// - input channel s_axis: one request per beat; tuser carries the command
//   (put byte, get burst, peek burst, clear), tdata the burst length and the
//   byte to store, tlast marks the final beat of a put run
// - output channel m_axis: put runs (on their last beat), clear, rejected or
//   zero-length get/peek give one result; a good get/peek gives one result
//   per byte, tlast set on the final one of the burst
// - every result carries status, the byte read, fill level and full mark as
//   they stand after the request
// throughput
// - put, clear and single results: one request per cycle while the output is
//   not stalled, result in the output register the cycle after acceptance
// - get/peek of n bytes: first byte through the read address, ram read and
//   output registers, then one byte per cycle via the ram read port while
//   unstalled; no request is taken until the last byte has left the read stage
// reset: indices, fill count and any open put run cleared, output empty;
//   the byte store needs no clearing pass
// stall: results sit in the output register; the ram read stage pauses and
//   input ready drops until the output register frees up
`default_nettype none

module byte_ring_buffer_burst #(
	parameter int unsigned DEPTH     = brb_pkg::DEPTH_DEF,
	parameter int unsigned MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// [6:0] length, [14:7] data_byte, [15] zero
	input  wire logic [brb_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] cmd
	input  wire logic [brb_pkg::CMD_W-1:0]     s_axis_tuser,
	input  wire logic                          s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// [0] status, [8:1] read_byte, [19:9] fill_level, [20] is_full, [23:21] zero
	output logic [brb_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	output logic                               m_axis_tlast
);

	localparam int unsigned LEN_W  = brb_pkg::LEN_W;
	localparam int unsigned BYTE_W = brb_pkg::BYTE_W;
	localparam int unsigned FILL_W = brb_pkg::FILL_W;
	localparam int unsigned IW     = $clog2(DEPTH);
	localparam int unsigned CNTW   = $clog2(DEPTH + 1);
	// common width for index sums and length/fill compares
	localparam int unsigned CW     = ((CNTW > LEN_W) ? CNTW : LEN_W) + 1;

	localparam logic [CW-1:0]   DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0]   MAXB_C  = CW'(MAX_BURST);
	localparam logic [CNTW-1:0] FULL_C  = CNTW'(DEPTH);
	localparam logic [IW-1:0]   LAST_IX = IW'(DEPTH - 1);

	// control state
	brb_pkg::state_t   state_q, state_d;
	logic [IW-1:0]     wi_q, wi_d;         // write index
	logic [IW-1:0]     ri_q, ri_d;         // read index
	logic [CNTW-1:0]   fill_q, fill_d;     // bytes held
	logic              put_act_q, put_act_d;
	logic              put_acc_q, put_acc_d;
	logic [LEN_W-1:0]  put_off_q, put_off_d;

	// burst read sequencer
	logic [IW-1:0]     rd_addr_q, rd_addr_d;
	logic [LEN_W-1:0]  rem_q, rem_d;       // reads still to issue
	logic              rd_vld_s1, rd_vld_d;
	logic              rd_end_s1, rd_end_d;

	// output register
	logic              out_vld_q, out_vld_d;
	logic              out_status_q, out_status_d;
	logic [BYTE_W-1:0] out_byte_q, out_byte_d;
	logic              out_end_q, out_end_d;
	logic [FILL_W-1:0] out_fill_q, out_fill_d;
	logic              out_full_q, out_full_d;

	// ram ports
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic              ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	// request fields
	brb_pkg::cmd_t     cmd;
	logic [LEN_W-1:0]  len;
	logic [BYTE_W-1:0] data_byte;
	logic              s_acc;

	// datapath terms
	logic              out_free;
	logic              s1_move;
	logic [CW-1:0]     len_c;
	logic [CW-1:0]     fill_c;
	logic [CW-1:0]     free_c;
	logic              starting;
	logic              put_ok;
	logic [LEN_W-1:0]  off;
	logic [CW-1:0]     off_c;
	logic              do_wr;
	logic [LEN_W-1:0]  off_nx;
	logic [CW-1:0]     wr_sum;
	logic [CW-1:0]     wi_sum;
	logic [IW-1:0]     wi_wrap;
	logic [CW-1:0]     ri_sum;
	logic [IW-1:0]     ri_wrap;
	logic [IW-1:0]     rd_inc;
	logic              get_err;
	logic              get_zero;
	logic              res_ld;
	logic              res_status;

	assign cmd       = brb_pkg::cmd_t'(s_axis_tuser);
	assign len       = s_axis_tdata[LEN_W-1:0];
	assign data_byte = s_axis_tdata[LEN_W+BYTE_W-1:LEN_W];

	assign out_free      = !out_vld_q || m_axis_tready;
	assign s1_move       = rd_vld_s1 && out_free;
	// one request at a time; a burst holds off new requests until drained
	assign s_axis_tready = (state_q == brb_pkg::ST_IDLE) && out_free;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	assign len_c  = CW'(len);
	assign fill_c = CW'(fill_q);
	assign free_c = DEPTH_C - fill_c;

	// put run: length and space check on the first beat, then one byte per beat up to the length while room
	assign starting = !put_act_q;
	assign put_ok   = starting ? ((len_c <= MAXB_C) && (len_c <= free_c)) : put_acc_q;
	assign off      = starting ? '0 : put_off_q;
	assign off_c    = CW'(off);
	assign do_wr    = put_ok && (off_c < len_c) && (off_c < MAXB_C) && (off_c < free_c);
	assign off_nx   = off + LEN_W'(do_wr);

	// offsets stay below the depth, so one conditional subtract wraps
	assign wr_sum    = CW'(wi_q) + off_c;
	assign ram_waddr = (wr_sum >= DEPTH_C) ? IW'(wr_sum - DEPTH_C) : IW'(wr_sum);
	assign wi_sum    = CW'(wi_q) + CW'(off_nx);
	assign wi_wrap   = (wi_sum >= DEPTH_C) ? IW'(wi_sum - DEPTH_C) : IW'(wi_sum);
	assign ri_sum    = CW'(ri_q) + len_c;
	assign ri_wrap   = (ri_sum >= DEPTH_C) ? IW'(ri_sum - DEPTH_C) : IW'(ri_sum);
	assign rd_inc    = (rd_addr_q == LAST_IX) ? '0 : rd_addr_q + IW'(1);

	assign get_err  = (len_c > fill_c) || (len_c > MAXB_C);
	assign get_zero = (len == '0);

	always_comb begin
		state_d    = state_q;
		wi_d       = wi_q;
		ri_d       = ri_q;
		fill_d     = fill_q;
		put_act_d  = put_act_q;
		put_acc_d  = put_acc_q;
		put_off_d  = put_off_q;
		rd_addr_d  = rd_addr_q;
		rem_d      = rem_q;
		rd_vld_d   = rd_vld_s1;
		rd_end_d   = rd_end_s1;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		res_ld     = 1'b0;
		res_status = 1'b0;

		unique case (state_q)
			brb_pkg::ST_IDLE: begin
				if (s_acc) begin
					unique case (cmd)
						brb_pkg::CMD_PUT: begin
							ram_we = do_wr;
							if (s_axis_tlast) begin
								// commit the bytes of the run and report
								wi_d       = wi_wrap;
								fill_d     = CNTW'(fill_c + CW'(off_nx));
								put_act_d  = 1'b0;
								put_acc_d  = 1'b0;
								put_off_d  = '0;
								res_ld     = 1'b1;
								res_status = !put_ok;
							end else begin
								put_act_d = 1'b1;
								put_acc_d = put_ok;
								put_off_d = off_nx;
							end
						end
						brb_pkg::CMD_GET, brb_pkg::CMD_PEEK: begin
							if (get_err || get_zero) begin
								res_ld     = 1'b1;
								res_status = get_err;
							end else begin
								rd_addr_d = ri_q;
								rem_d     = len;
								state_d   = brb_pkg::ST_STREAM;
								if (cmd == brb_pkg::CMD_GET) begin
									ri_d   = ri_wrap;
									fill_d = CNTW'(fill_c - len_c);
								end
							end
						end
						brb_pkg::CMD_CLEAR: begin
							wi_d      = '0;
							ri_d      = '0;
							fill_d    = '0;
							put_act_d = 1'b0;
							put_acc_d = 1'b0;
							put_off_d = '0;
							res_ld    = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			brb_pkg::ST_STREAM: begin
				// issue a read when the read stage is empty or empties now
				ram_re = (rem_q != '0) && (!rd_vld_s1 || s1_move);
				if (ram_re) begin
					rd_addr_d = rd_inc;
					rem_d     = rem_q - LEN_W'(1);
					rd_vld_d  = 1'b1;
					rd_end_d  = (rem_q == LEN_W'(1));
				end else if (s1_move) begin
					rd_vld_d = 1'b0;
				end
				if ((rem_q == '0) && (!rd_vld_s1 || s1_move)) begin
					state_d = brb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = brb_pkg::ST_IDLE;
			end
		endcase
	end

	// output register load; fill is the post-request value in both cases
	always_comb begin
		out_vld_d    = out_vld_q && !m_axis_tready;
		out_status_d = out_status_q;
		out_byte_d   = out_byte_q;
		out_end_d    = out_end_q;
		out_fill_d   = out_fill_q;
		out_full_d   = out_full_q;
		if (res_ld) begin
			out_vld_d    = 1'b1;
			out_status_d = res_status;
			out_byte_d   = '0;
			out_end_d    = 1'b1;
			out_fill_d   = FILL_W'(fill_d);
			out_full_d   = (fill_d == FULL_C);
		end else if (s1_move) begin
			out_vld_d    = 1'b1;
			out_status_d = 1'b0;
			out_byte_d   = ram_rdata;
			out_end_d    = rd_end_s1;
			out_fill_d   = FILL_W'(fill_d);
			out_full_d   = (fill_d == FULL_C);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= brb_pkg::ST_IDLE;
			wi_q      <= '0;
			ri_q      <= '0;
			fill_q    <= '0;
			put_act_q <= 1'b0;
			put_acc_q <= 1'b0;
			put_off_q <= '0;
			rem_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			wi_q      <= wi_d;
			ri_q      <= ri_d;
			fill_q    <= fill_d;
			put_act_q <= put_act_d;
			put_acc_q <= put_acc_d;
			put_off_q <= put_off_d;
			rem_q     <= rem_d;
			rd_vld_s1 <= rd_vld_d;
			out_vld_q <= out_vld_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_addr_q    <= rd_addr_d;
		rd_end_s1    <= rd_end_d;
		out_status_q <= out_status_d;
		out_byte_q   <= out_byte_d;
		out_end_q    <= out_end_d;
		out_fill_q   <= out_fill_d;
		out_full_q   <= out_full_d;
	end

	brb_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (data_byte),
		.rd_en   (ram_re),
		.rd_addr (rd_addr_q),
		.rd_data (ram_rdata)
	);

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tdata  = {{brb_pkg::M_PAD_W{1'b0}}, out_full_q, out_fill_q,
		out_byte_q, out_status_q};

endmodule

`default_nettype wire

FILE: src/brb_checker.sv
// port-level checks for the byte ring buffer, bound to the top level
`default_nettype none

module brb_checker #(
	parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_axis_tvalid,
	input wire logic                          s_axis_tready,
	input wire logic                          m_axis_tvalid,
	input wire logic                          m_axis_tready,
	input wire logic [brb_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input wire logic                          m_axis_tlast
);

	localparam int unsigned FW = brb_pkg::FILL_W;
	localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled result changed");

	// full mark agrees with the fill level
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20] |-> m_axis_tdata[19:9] == FULL_FILL)
		else $error("full mark without full fill level");

	// a rejection is a single result with no byte
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tlast && m_axis_tdata[8:1] == '0)
		else $error("rejected result is not a lone empty result");

	// no request taken while a burst is still coming out
	a_burst_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("request accepted during a burst");

	// fill level constant across the bytes of one burst
	a_burst_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			!m_axis_tvalid || m_axis_tdata[19:9] == $past(m_axis_tdata[19:9]))
		else $error("fill level moved within a burst");

endmodule

bind byte_ring_buffer_burst brb_checker #(
	.DEPTH (DEPTH)
) u_brb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/sv/byte_ring_buffer_burst_test.sv
// self-checking testbench for the byte ring buffer with all-or-nothing bursts
`default_nettype none

module byte_ring_buffer_burst_test;
	timeunit 1ns;
	timeprecision 1ps;

	import brb_pkg::*;

	localparam int unsigned RING_DEPTH = DEPTH_DEF;
	localparam int unsigned BURST_MAX  = MAX_BURST_DEF;
	// longest stretch with no request or result moving before the run is called hung
	localparam int unsigned HANG_LIMIT = 2000;
	localparam int unsigned RANDOM_REQUESTS = 150;

	// one result as it should appear on the output stream
	typedef struct packed {
		logic              status;
		logic [BYTE_W-1:0] read_byte;
		logic              end_of_run;
		logic [FILL_W-1:0] fill_level;
		logic              is_full;
	} ring_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0] s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;

	// mirror of the buffer: byte store, indices, full mark and the open put run
	logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
	int unsigned wr_ptr;
	int unsigned rd_ptr;
	bit full_mark;
	bit run_open;
	bit run_ok;
	int unsigned run_count;

	ring_result_t pending_results [$];
	int unsigned error_count;
	int unsigned requests_sent;
	// set for the final stretch of traffic: no gaps, no stalls
	bit quiet_tail;

	byte_ring_buffer_burst dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bytes held right now, telling full from empty by the full mark
	function automatic int unsigned ring_fill();
		if (full_mark)
			return RING_DEPTH;
		return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
	endfunction

	// largest read the buffer can serve at the moment
	function automatic int unsigned readable_bytes();
		int unsigned fill;
		fill = ring_fill();
		return (fill < BURST_MAX) ? fill : BURST_MAX;
	endfunction

	function automatic void record_result(bit status, logic [BYTE_W-1:0] rbyte, bit eor);
		ring_result_t res;
		res.status     = status;
		res.read_byte  = rbyte;
		res.end_of_run = eor;
		res.fill_level = FILL_W'(ring_fill());
		res.is_full    = full_mark;
		pending_results.push_back(res);
	endfunction

	// advance the mirror by one accepted request and queue the results it causes
	function automatic void track_request(cmd_t cmd, int unsigned len,
			logic [BYTE_W-1:0] data, bit last);
		int unsigned free_space;
		int unsigned start;
		case (cmd)
			CMD_PUT: begin
				free_space = RING_DEPTH - ring_fill();
				// first item of a run decides the whole burst
				if (!run_open) begin
					run_open  = 1'b1;
					run_count = 0;
					run_ok    = (len <= BURST_MAX) && (len <= free_space);
				end
				if (run_ok && run_count < len && run_count < BURST_MAX &&
						run_count < free_space) begin
					ring_mem[(wr_ptr + run_count) % RING_DEPTH] = data;
					run_count++;
				end
				if (!last)
					return;
				// bytes become visible only when the run closes
				if (run_ok && run_count > 0) begin
					wr_ptr    = (wr_ptr + run_count) % RING_DEPTH;
					full_mark = (wr_ptr == rd_ptr);
				end
				run_open  = 1'b0;
				run_count = 0;
				record_result(!run_ok, '0, 1'b1);
				run_ok = 1'b0;
			end
			CMD_CLEAR: begin
				wr_ptr    = 0;
				rd_ptr    = 0;
				full_mark = 1'b0;
				run_open  = 1'b0;
				run_ok    = 1'b0;
				run_count = 0;
				record_result(1'b0, '0, 1'b1);
			end
			default: begin
				// get and peek: whole burst, a single error, or a single result for length zero
				if (len > ring_fill() || len > BURST_MAX) begin
					record_result(1'b1, '0, 1'b1);
				end else if (len == 0) begin
					record_result(1'b0, '0, 1'b1);
				end else begin
					start = rd_ptr;
					if (cmd == CMD_GET) begin
						rd_ptr    = (rd_ptr + len) % RING_DEPTH;
						full_mark = 1'b0;
					end
					for (int unsigned k = 0; k < len; k++)
						record_result(1'b0, ring_mem[(start + k) % RING_DEPTH], k + 1 == len);
				end
			end
		endcase
	endfunction

	// drive one request from a falling edge and hold it until it is taken
	task automatic send_request(cmd_t cmd, logic [LEN_W-1:0] len,
			logic [BYTE_W-1:0] data, bit last);
		@(negedge clk);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{S_PAD_W{1'b0}}, data, len};
		s_axis_tuser  <= cmd;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		track_request(cmd, 32'(len), data, last);
		requests_sent++;
	endtask

	// hold off the sender until every queued result has come out
	task automatic wait_results_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// well-formed put run of len items, optionally with a read served before one of them
	task automatic put_burst(int unsigned len, bit read_inside);
		int unsigned cut;
		cut = $urandom_range(0, len - 1);
		for (int unsigned k = 0; k < len; k++) begin
			if (read_inside && k == cut)
				send_request($urandom_range(0, 1) ? CMD_GET : CMD_PEEK,
					LEN_W'($urandom_range(0, readable_bytes() < 8 ? readable_bytes() : 8)),
					BYTE_W'($urandom), 1'b0);
			send_request(CMD_PUT, LEN_W'(len), BYTE_W'($urandom), k + 1 == len);
		end
	endtask

	// corner requests: empty buffer, zero lengths, over-long lengths, short put
	// runs, runs closed early or late, a read inside a run, clear aborting a run
	task automatic test_corner_requests();
		send_request(CMD_GET, 0, 8'h00, 1'b0);
		send_request(CMD_PEEK, 1, 8'hFF, 1'b1);
		send_request(CMD_PUT, 0, 8'hFF, 1'b1);
		send_request(CMD_PUT, 4, 8'h00, 1'b0);
		send_request(CMD_PUT, 4, 8'hFF, 1'b0);
		send_request(CMD_PUT, 4, 8'h55, 1'b0);
		send_request(CMD_PUT, 4, 8'hAA, 1'b1);
		send_request(CMD_PEEK, 4, 8'h00, 1'b0);
		send_request(CMD_GET, 3, 8'h00, 1'b1);
		send_request(CMD_GET, LEN_W'(BURST_MAX + 1), 8'h00, 1'b0);
		send_request(CMD_PEEK, 7'h7F, 8'hFF, 1'b1);
		send_request(CMD_PUT, 7'h7F, 8'h12, 1'b1);
		// run announced as three bytes but closed after two, read served inside
		send_request(CMD_PUT, 3, 8'h3C, 1'b0);
		send_request(CMD_GET, 1, 8'h00, 1'b0);
		send_request(CMD_PUT, 3, 8'hC3, 1'b1);
		// one byte announced, three sent: the extras are dropped
		send_request(CMD_PUT, 1, 8'h81, 1'b0);
		send_request(CMD_PUT, 1, 8'h7E, 1'b0);
		send_request(CMD_PUT, 1, 8'h18, 1'b1);
		// clear in the middle of a run throws it away
		send_request(CMD_PUT, 2, 8'hE7, 1'b0);
		send_request(CMD_CLEAR, 0, 8'h00, 1'b0);
		send_request(CMD_PUT, 1, 8'h5A, 1'b1);
		send_request(CMD_PEEK, 1, 8'h00, 1'b1);
		send_request(CMD_GET, 1, 8'h00, 1'b0);
		send_request(CMD_CLEAR, 7'h7F, 8'hFF, 1'b1);
		wait_results_drained();
	endtask

	// fill to the brim from an offset so both indices wrap, then empty it again
	task automatic test_full_and_wrap();
		send_request(CMD_CLEAR, 0, 8'h00, 1'b0);
		put_burst(10, 1'b0);
		send_request(CMD_GET, 10, 8'h00, 1'b0);
		for (int k = 0; k < RING_DEPTH / BURST_MAX; k++)
			put_burst(BURST_MAX, 1'b0);
		// full: a one-byte put is refused, an empty put changes nothing
		send_request(CMD_PUT, 1, 8'hA5, 1'b1);
		send_request(CMD_PUT, 0, 8'h5A, 1'b1);
		send_request(CMD_PEEK, LEN_W'(BURST_MAX), 8'h00, 1'b0);
		send_request(CMD_GET, LEN_W'(BURST_MAX + 1), 8'h00, 1'b0);
		send_request(CMD_GET, LEN_W'(BURST_MAX), 8'h00, 1'b0);
		put_burst(BURST_MAX, 1'b0);
		wait_results_drained();
		for (int k = 0; k < RING_DEPTH / BURST_MAX; k++)
			send_request(CMD_GET, LEN_W'(BURST_MAX), 8'h00, 1'b0);
		send_request(CMD_GET, 1, 8'h00, 1'b0);
		wait_results_drained();
	endtask

	// mostly well-formed runs and reads, with over-long reads, clears and
	// ragged put runs mixed in; the tail runs without gaps or stalls
	task automatic test_random_traffic();
		int unsigned first;
		int unsigned pick;
		int unsigned len;
		int unsigned pieces;
		first = requests_sent;
		while (requests_sent - first < RANDOM_REQUESTS) begin
			quiet_tail = (requests_sent - first >= RANDOM_REQUESTS - 30);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, BURST_MAX)
					: $urandom_range(1, 20);
				put_burst(len, $urandom_range(0, 6) == 0);
			end else if (pick < 75) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, readable_bytes())
					: $urandom_range(0, readable_bytes() < 16 ? readable_bytes() : 16);
				send_request($urandom_range(0, 1) ? CMD_GET : CMD_PEEK, LEN_W'(len),
					BYTE_W'($urandom), 1'($urandom_range(0, 1)));
			end else if (pick < 85) begin
				len = $urandom_range(0, 1) ? readable_bytes() + 1
					: $urandom_range(readable_bytes() + 1, 127);
				send_request($urandom_range(0, 1) ? CMD_GET : CMD_PEEK, LEN_W'(len),
					BYTE_W'($urandom), 1'($urandom_range(0, 1)));
			end else if (pick < 90) begin
				send_request(CMD_CLEAR, LEN_W'($urandom), BYTE_W'($urandom),
					1'($urandom_range(0, 1)));
			end else begin
				// ragged run: lengths differ per item, may stay open
				pieces = $urandom_range(1, 6);
				for (int unsigned k = 0; k < pieces; k++)
					send_request(CMD_PUT, LEN_W'($urandom_range(0, 127)), BYTE_W'($urandom),
						(k + 1 == pieces) ? ($urandom_range(0, 3) != 0) : 1'b0);
			end
			if ($urandom_range(0, 29) == 0)
				wait_results_drained();
		end
	endtask

	// output side stalls in short bursts until the quiet tail
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// compare every result taken off the output with the oldest expectation
	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n === 1'b1 && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("status", 32'(want.status), 32'(m_axis_tdata[0]));
				check_field("read_byte", 32'(want.read_byte), 32'(m_axis_tdata[8:1]));
				check_field("end_of_run", 32'(want.end_of_run), 32'(m_axis_tlast));
				check_field("fill_level", 32'(want.fill_level), 32'(m_axis_tdata[19:9]));
				check_field("is_full", 32'(want.is_full), 32'(m_axis_tdata[20]));
			end
		end
	end

	// hang guard: cycles in which neither side moves anything
	initial begin : watchdog
		int unsigned still_cycles;
		still_cycles = 0;
		while (still_cycles < HANG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				still_cycles = 0;
			else
				still_cycles++;
		end
		$display("byte_ring_buffer_burst verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_PUT;
		s_axis_tlast  = 1'b0;
		quiet_tail    = 1'b0;
		error_count   = 0;
		requests_sent = 0;
		wr_ptr        = 0;
		rd_ptr        = 0;
		full_mark     = 1'b0;
		run_open      = 1'b0;
		run_ok        = 1'b0;
		run_count     = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_corner_requests();
		test_full_and_wrap();
		test_random_traffic();

		wait_results_drained();
		// let anything stray show up before the verdict
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("byte_ring_buffer_burst verification clean");
		else
			$display("byte_ring_buffer_burst verification failed");
		$finish;
	end

endmodule

`default_nettype wire
